/* rtl/tmet_pkg.sv */
package tmet_pkg;

  localparam int READING_BITS = 10;
  localparam int CFG_INDEX_BITS = 2;
  localparam int EVENT_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_TOUCH_LEVEL = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOUCH_MARGIN = 2'd1;

  localparam logic [READING_BITS-1:0] TOUCH_LEVEL_RESET = 10'd1023;
  localparam logic [READING_BITS-1:0] TOUCH_MARGIN_RESET = 10'd20;

  localparam logic [EVENT_BITS-1:0] EV_NONE = 2'd0;
  localparam logic [EVENT_BITS-1:0] EV_TOUCH = 2'd1;
  localparam logic [EVENT_BITS-1:0] EV_DRAG = 2'd2;

  typedef struct packed {
    logic [READING_BITS-1:0] contact_reading;
    logic [READING_BITS-1:0] x_reading;
    logic [READING_BITS-1:0] y_reading;
  } tmet_in_t;

  typedef struct packed {
    logic [EVENT_BITS-1:0]   event_kind;
    logic [READING_BITS-1:0] x_median;
    logic [READING_BITS-1:0] y_median;
  } tmet_out_t;

  typedef struct packed {
    logic                    shift;
    logic                    start;
    logic [READING_BITS-1:0] x_sample;
    logic [READING_BITS-1:0] y_sample;
  } tmet_med_ctl_t;

  typedef struct packed {
    logic                    done;
    logic [READING_BITS-1:0] x_median;
    logic [READING_BITS-1:0] y_median;
  } tmet_med_sts_t;

endpackage

/* rtl/touch_median_event_tracker.sv */
// An in-window sample that completes no collection is absorbed while the block stays
// idle; an out-of-window sample passes through S_PUSH to the output register. A completing
// sample runs the rank search of the shared comparator pair, a load and a scan of every
// ring entry per candidate for at most SAMPLE_COUNT candidates, then S_PUSH to the output.
// The input stalls in S_MED and S_PUSH; S_PUSH waits while out_stall holds a full output.
// Reset: synchronous, active low; control and config registers return to defaults, no touch.
module touch_median_event_tracker
  import tmet_pkg::*;
#(
  parameter int SAMPLE_COUNT = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tmet_in_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tmet_out_t                 out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [READING_BITS-1:0]   cfg_data
);

  localparam int CW = $clog2(SAMPLE_COUNT + 1);

  typedef enum logic [1:0] {S_IDLE, S_MED, S_PUSH} state_t;

  state_t                  state_r;
  logic [READING_BITS-1:0] level_r, margin_r;
  logic [CW-1:0]           count_r;
  logic [EVENT_BITS-1:0]   touch_r;
  tmet_out_t               res_r, out_r;
  logic                    out_valid_r;

  tmet_med_ctl_t           med_ctl;
  tmet_med_sts_t           med_sts;

  logic                    in_acc, sample_ok, complete;
  logic [READING_BITS-1:0] distance;
  logic [CW-1:0]           count_inc;
  logic [EVENT_BITS-1:0]   touch_nxt;
  logic                    slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // True distance, so a margin above the level opens the window down to zero.
  assign distance = (in_data.contact_reading >= level_r) ?
                    (in_data.contact_reading - level_r) :
                    (level_r - in_data.contact_reading);
  assign sample_ok = (distance <= margin_r);
  assign count_inc = count_r + CW'(1);
  assign complete  = (count_inc == CW'(SAMPLE_COUNT));
  assign touch_nxt = (touch_r == EV_NONE) ? EV_TOUCH : EV_DRAG;
  assign slot_free = !out_valid_r || !out_stall;

  assign med_ctl.shift    = in_acc && sample_ok;
  assign med_ctl.start    = in_acc && sample_ok && complete;
  assign med_ctl.x_sample = in_data.x_reading;
  assign med_ctl.y_sample = in_data.y_reading;

  tmet_median #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_median (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (med_ctl),
    .sts  (med_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= TOUCH_LEVEL_RESET;
      margin_r <= TOUCH_MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TOUCH_LEVEL:  level_r <= cfg_data;
        REG_TOUCH_MARGIN: margin_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      touch_r     <= EV_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_PUSH)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (!sample_ok) begin
              count_r <= '0;
              touch_r <= EV_NONE;
              res_r   <= '{event_kind: EV_NONE, x_median: '0, y_median: '0};
              state_r <= S_PUSH;
            end else if (complete) begin
              count_r <= '0;
              touch_r <= touch_nxt;
              res_r.event_kind <= touch_nxt;
              state_r <= S_MED;
            end else begin
              count_r <= count_inc;
            end
          end
        end
        S_MED: begin
          if (med_sts.done) begin
            res_r.x_median <= med_sts.x_median;
            res_r.y_median <= med_sts.y_median;
            state_r        <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (slot_free) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/tmet_median.sv */
module tmet_median
  import tmet_pkg::*;
#(
  parameter int SAMPLE_COUNT = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tmet_med_ctl_t ctl,
  output tmet_med_sts_t sts
);

  localparam int IW = $clog2(SAMPLE_COUNT);
  localparam int CW = $clog2(SAMPLE_COUNT + 1);
  localparam int MID = SAMPLE_COUNT / 2;

  typedef enum logic [1:0] {M_IDLE, M_LOAD, M_SCAN} med_state_t;

  med_state_t state_r;

  // Sample rings: new samples shift in at the tail, and during the search the
  // ring rotates so that every entry passes the head once per pass.
  logic [READING_BITS-1:0] ring_x_r [SAMPLE_COUNT];
  logic [READING_BITS-1:0] ring_y_r [SAMPLE_COUNT];

  logic [READING_BITS-1:0] cand_x_r, cand_y_r;
  logic [CW-1:0]           less_x_r, leq_x_r, less_y_r, leq_y_r;
  logic [IW-1:0]           pass_r, step_r;
  logic                    found_x_r, found_y_r;
  logic                    done_r;
  logic [READING_BITS-1:0] med_x_r, med_y_r;

  logic          rotate;
  logic [CW-1:0] less_x_nxt, leq_x_nxt, less_y_nxt, leq_y_nxt;
  logic          hit_x, hit_y, last_step;

  assign rotate = (state_r == M_LOAD) || (state_r == M_SCAN);

  // Shared comparator pair: head of each ring against the current candidate.
  assign less_x_nxt = less_x_r + CW'(ring_x_r[0] < cand_x_r);
  assign leq_x_nxt  = leq_x_r + CW'(ring_x_r[0] <= cand_x_r);
  assign less_y_nxt = less_y_r + CW'(ring_y_r[0] < cand_y_r);
  assign leq_y_nxt  = leq_y_r + CW'(ring_y_r[0] <= cand_y_r);

  assign last_step = (step_r == IW'(SAMPLE_COUNT - 1));
  // The candidate is the median when it can sit at the middle sorted position.
  assign hit_x = last_step && (less_x_nxt <= CW'(MID)) && (leq_x_nxt > CW'(MID));
  assign hit_y = last_step && (less_y_nxt <= CW'(MID)) && (leq_y_nxt > CW'(MID));

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int k = 0; k < SAMPLE_COUNT - 1; k++) begin
        ring_x_r[k] <= ring_x_r[k+1];
        ring_y_r[k] <= ring_y_r[k+1];
      end
      ring_x_r[SAMPLE_COUNT-1] <= ctl.x_sample;
      ring_y_r[SAMPLE_COUNT-1] <= ctl.y_sample;
    end else if (rotate) begin
      for (int k = 0; k < SAMPLE_COUNT - 1; k++) begin
        ring_x_r[k] <= ring_x_r[k+1];
        ring_y_r[k] <= ring_y_r[k+1];
      end
      ring_x_r[SAMPLE_COUNT-1] <= ring_x_r[0];
      ring_y_r[SAMPLE_COUNT-1] <= ring_y_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= M_IDLE;
      done_r    <= 1'b0;
      found_x_r <= 1'b0;
      found_y_r <= 1'b0;
      pass_r    <= '0;
      step_r    <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (ctl.start) begin
            found_x_r <= 1'b0;
            found_y_r <= 1'b0;
            pass_r    <= '0;
            state_r   <= M_LOAD;
          end
        end
        M_LOAD: begin
          cand_x_r <= ring_x_r[0];
          cand_y_r <= ring_y_r[0];
          less_x_r <= '0;
          leq_x_r  <= '0;
          less_y_r <= '0;
          leq_y_r  <= '0;
          step_r   <= '0;
          state_r  <= M_SCAN;
        end
        M_SCAN: begin
          less_x_r <= less_x_nxt;
          leq_x_r  <= leq_x_nxt;
          less_y_r <= less_y_nxt;
          leq_y_r  <= leq_y_nxt;
          step_r   <= step_r + IW'(1);
          if (hit_x && !found_x_r) begin
            med_x_r   <= cand_x_r;
            found_x_r <= 1'b1;
          end
          if (hit_y && !found_y_r) begin
            med_y_r   <= cand_y_r;
            found_y_r <= 1'b1;
          end
          if (last_step) begin
            if (((found_x_r || hit_x) && (found_y_r || hit_y)) ||
                (pass_r == IW'(SAMPLE_COUNT - 1))) begin
              done_r  <= 1'b1;
              state_r <= M_IDLE;
            end else begin
              pass_r  <= pass_r + IW'(1);
              state_r <= M_LOAD;
            end
          end
        end
        default: begin
          state_r <= M_IDLE;
        end
      endcase
    end
  end

  assign sts.done     = done_r;
  assign sts.x_median = med_x_r;
  assign sts.y_median = med_y_r;

endmodule

/* bench/touch_result_checker.sv */
`timescale 1ns / 100ps

module touch_result_checker
  import tmet_pkg::*;
#(
  parameter int SAMPLES = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  tmet_in_t                  in_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  tmet_out_t                 out_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [READING_BITS-1:0]   cfg_data,
  output int                        pending,
  output int                        fail_count
);

  logic [READING_BITS-1:0] level_q;
  logic [READING_BITS-1:0] margin_q;
  logic [READING_BITS-1:0] x_hist [SAMPLES];
  logic [READING_BITS-1:0] y_hist [SAMPLES];
  int                      fill;
  logic [EVENT_BITS-1:0]   touch_now;
  tmet_out_t               expected_reports [$];
  int                      mismatches;

  function automatic logic [READING_BITS-1:0] median_pick(
    input logic [READING_BITS-1:0] vals [SAMPLES]
  );
    logic [READING_BITS-1:0] key;
    int j;
    for (int i = 1; i < SAMPLES; i++) begin
      key = vals[i];
      j = i - 1;
      while (j >= 0 && vals[j] > key) begin
        vals[j+1] = vals[j];
        j--;
      end
      vals[j+1] = key;
    end
    return vals[SAMPLES/2];
  endfunction

  // A collection completes on the last of SAMPLES consecutive in-window
  // samples; any out-of-window sample drops the touch immediately.
  function automatic void track_sample(input tmet_in_t s);
    int distance;
    tmet_out_t res;
    distance = int'(s.contact_reading) - int'(level_q);
    if (distance < 0) begin
      distance = -distance;
    end
    if (distance > int'(margin_q)) begin
      fill = 0;
      touch_now = EV_NONE;
      res.event_kind = EV_NONE;
      res.x_median = '0;
      res.y_median = '0;
      expected_reports.push_back(res);
      return;
    end
    x_hist[fill] = s.x_reading;
    y_hist[fill] = s.y_reading;
    fill++;
    if (fill < SAMPLES) begin
      return;
    end
    fill = 0;
    touch_now = (touch_now == EV_NONE) ? EV_TOUCH : EV_DRAG;
    res.event_kind = touch_now;
    res.x_median = median_pick(x_hist);
    res.y_median = median_pick(y_hist);
    expected_reports.push_back(res);
  endfunction

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  always @(posedge clk) begin
    tmet_out_t want;
    if (!rst_n) begin
      level_q = TOUCH_LEVEL_RESET;
      margin_q = TOUCH_MARGIN_RESET;
      fill = 0;
      touch_now = EV_NONE;
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TOUCH_LEVEL) begin
          level_q = cfg_data;
        end else if (cfg_index == REG_TOUCH_MARGIN) begin
          margin_q = cfg_data;
        end
      end
      if (in_valid && !in_stall) begin
        track_sample(in_data);
      end
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          note_failure($sformatf("result with nothing expected: event %0d x %0d y %0d",
                                 out_data.event_kind, out_data.x_median,
                                 out_data.y_median));
        end else begin
          want = expected_reports.pop_front();
          if (out_data.event_kind !== want.event_kind ||
              out_data.x_median !== want.x_median ||
              out_data.y_median !== want.y_median) begin
            note_failure($sformatf(
              "mismatch: expected event %0d x %0d y %0d, got event %0d x %0d y %0d",
              want.event_kind, want.x_median, want.y_median,
              out_data.event_kind, out_data.x_median, out_data.y_median));
          end
        end
      end
    end
    pending <= expected_reports.size();
    fail_count <= mismatches;
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
  import tmet_pkg::*;

  localparam int SAMPLE_COUNT = 7;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int SETTLE_CYCLES = 80;
  localparam int READING_MAX = 1023;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  tmet_in_t                  in_data;
  logic                      out_valid;
  logic                      out_stall;
  tmet_out_t                 out_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [READING_BITS-1:0]   cfg_data;
  int                        pending;
  int                        fail_count;

  int send_gap_pct;
  int stall_pct;
  int cur_level;
  int cur_margin;
  int phase_level [PHASES] = '{1023, 0, 512, 5, 1023, 700, 0, 1000};
  int phase_margin [PHASES] = '{20, 0, 1023, 300, 1023, 37, 1023, 500};

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  touch_median_event_tracker #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  touch_result_checker #(
    .SAMPLES(SAMPLE_COUNT)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .fail_count(fail_count)
  );

  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  function automatic logic [READING_BITS-1:0] any_reading();
    int r;
    r = $urandom_range(9);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return READING_BITS'(READING_MAX);
    end
    return READING_BITS'($urandom_range(READING_MAX));
  endfunction

  // Picks a contact reading inside or outside the current window, often on
  // its edges. When the window covers every reading, an in-window one is used.
  function automatic logic [READING_BITS-1:0] pick_contact(input bit hit);
    int lo;
    int hi;
    int r;
    lo = (cur_level - cur_margin < 0) ? 0 : cur_level - cur_margin;
    hi = (cur_level + cur_margin > READING_MAX) ? READING_MAX : cur_level + cur_margin;
    r = $urandom_range(3);
    if (hi - lo == READING_MAX) begin
      hit = 1'b1;
    end
    if (hit) begin
      return READING_BITS'((r == 0) ? lo : (r == 1) ? hi : $urandom_range(hi, lo));
    end
    if (lo > 0 && (hi == READING_MAX || $urandom_range(1) == 0)) begin
      return READING_BITS'((r < 2) ? lo - 1 : $urandom_range(lo - 1, 0));
    end
    return READING_BITS'((r < 2) ? hi + 1 : $urandom_range(READING_MAX, hi + 1));
  endfunction

  task automatic send_sample(input logic [READING_BITS-1:0] c,
                             input logic [READING_BITS-1:0] x,
                             input logic [READING_BITS-1:0] y);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{contact_reading: c, x_reading: x, y_reading: y};
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [READING_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    if (idx == REG_TOUCH_LEVEL) begin
      cur_level = val;
    end else if (idx == REG_TOUCH_MARGIN) begin
      cur_margin = val;
    end
  endtask

  // In-window samples that end no collection leave nothing pending, so the block may
  // still be busy after the last result; the extra cycles cover that.
  task automatic settle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int run;
    int sent;
    int r;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_TOUCH_LEVEL;
    cfg_data <= '0;
    send_gap_pct = 11;
    stall_pct = 50;
    cur_level = TOUCH_LEVEL_RESET;
    cur_margin = TOUCH_MARGIN_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed transactions at the reset window of 1003 to 1023.
    send_sample(10'd0, 10'd1023, 10'd1023);
    send_sample(10'd1023, 10'd0, 10'd1023);
    send_sample(10'd1003, 10'd1023, 10'd1023);
    send_sample(10'd1010, 10'd0, 10'd1023);
    send_sample(10'd1023, 10'd1023, 10'd0);
    send_sample(10'd1003, 10'd0, 10'd0);
    send_sample(10'd1023, 10'd1023, 10'd0);
    send_sample(10'd1015, 10'd512, 10'd1);
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      send_sample(READING_BITS'(10'd1023 - i), READING_BITS'(10'd700 - 10'd97 * i),
                  READING_BITS'(10'd5 * i + 10'd341));
    end
    send_sample(10'd1002, 10'd682, 10'd341);
    for (int i = 0; i < 3; i++) begin
      send_sample(10'd1020, 10'd555, 10'd666);
    end
    send_sample(10'd512, 10'd1023, 10'd0);

    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        send_gap_pct = 11;
        stall_pct = 50;
      end else if (p < 6) begin
        send_gap_pct = 50;
        stall_pct = 11;
      end else begin
        send_gap_pct = 0;
        stall_pct = 0;
      end
      if (p > 0) begin
        settle();
        if (p == 1) begin
          write_reg(REG_SPARE_LO, any_reading());
          write_reg(REG_SPARE_HI, any_reading());
        end
        write_reg(REG_TOUCH_LEVEL, READING_BITS'(phase_level[p]));
        write_reg(REG_TOUCH_MARGIN, READING_BITS'(phase_margin[p]));
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 70) begin
          run = ($urandom_range(3) == 0) ? $urandom_range(13, 1)
                                         : SAMPLE_COUNT * $urandom_range(3, 1);
          repeat (run) send_sample(pick_contact(1'b1), any_reading(), any_reading());
          sent += run;
        end else if (r < 85) begin
          send_sample(pick_contact(1'b0), any_reading(), any_reading());
          sent++;
        end else begin
          send_sample(READING_BITS'($urandom_range(READING_MAX)), any_reading(),
                      any_reading());
          sent++;
        end
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
